FILE: sv/qmr_pkg.sv
// Shared types, constants and the fixed-point multiply for the quaternion unit.
// Used by qmr_ham_pipe and quaternion_multiply_rotate; depends on nothing.
`default_nettype none

package qmr_pkg;

    localparam int WORD_W    = 32;
    localparam int FRAC_BITS = 16;

    typedef logic signed [WORD_W-1:0] word_t;

    typedef struct packed {
        word_t w;
        word_t x;
        word_t y;
        word_t z;
    } quat_t;

    // pass: return operand a unchanged; zero_w: force the scalar part to zero
    typedef struct packed {
        logic pass;
        logic zero_w;
    } ham_ctl_t;

    // sideband that travels with a word: command and conjugate of the first quaternion
    typedef struct packed {
        logic  cmd;
        quat_t conj;
    } tag_t;

    localparam logic CMD_MULTIPLY = 1'b0;
    localparam logic CMD_ROTATE   = 1'b1;

    // full signed product, arithmetic shift by the fraction bits, keep the low word
    function automatic word_t fx_mul(input word_t a, input word_t b);
        logic signed [2*WORD_W-1:0] p;
        p = (2*WORD_W)'(a) * (2*WORD_W)'(b);
        return word_t'(p >>> FRAC_BITS);
    endfunction

endpackage

`default_nettype wire

FILE: sv/qmr_ham_pipe.sv
// Two-stage pipelined Hamilton product: sixteen registered products, then sums.
// Depends on qmr_pkg for quat_t, ham_ctl_t, tag_t and fx_mul.
`default_nettype none

module qmr_ham_pipe
    import qmr_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     up_valid,
    output logic          up_ready,
    input  wire quat_t    a,
    input  wire quat_t    b,
    input  wire ham_ctl_t ctl,
    input  wire tag_t     up_tag,
    output logic          dn_valid,
    input  wire logic     dn_ready,
    output quat_t         res,
    output tag_t          dn_tag
);

    word_t    av [4];
    word_t    bv [4];
    word_t    prod_next [4][4];
    word_t    s1_prod_reg [4][4];
    quat_t    s1_a_reg;
    ham_ctl_t s1_ctl_reg;
    tag_t     s1_tag_reg;
    logic     s1_valid_reg;
    logic     s1_ready;
    quat_t    res_next;
    quat_t    s2_res_reg;
    tag_t     s2_tag_reg;
    logic     s2_valid_reg;
    logic     s2_ready;

    // a stage takes a word when it is empty or its word moves on
    assign s2_ready = !s2_valid_reg || dn_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign up_ready = s1_ready;

    always_comb
    begin
        av[0] = a.w;
        av[1] = a.x;
        av[2] = a.y;
        av[3] = a.z;
        bv[0] = b.w;
        bv[1] = b.x;
        bv[2] = b.y;
        bv[3] = b.z;
        for (int i = 0; i < 4; i++)
        begin
            for (int j = 0; j < 4; j++)
            begin
                prod_next[i][j] = fx_mul(av[i], bv[j]);
            end
        end
    end

    always_comb
    begin
        res_next.w = s1_prod_reg[0][0] - s1_prod_reg[1][1]
                   - s1_prod_reg[2][2] - s1_prod_reg[3][3];
        res_next.x = s1_prod_reg[0][1] + s1_prod_reg[1][0]
                   + s1_prod_reg[2][3] - s1_prod_reg[3][2];
        res_next.y = s1_prod_reg[0][2] + s1_prod_reg[2][0]
                   + s1_prod_reg[3][1] - s1_prod_reg[1][3];
        res_next.z = s1_prod_reg[0][3] + s1_prod_reg[3][0]
                   + s1_prod_reg[1][2] - s1_prod_reg[2][1];
        if (s1_ctl_reg.pass)
        begin
            res_next = s1_a_reg;
        end
        if (s1_ctl_reg.zero_w)
        begin
            res_next.w = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= up_valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && up_valid)
        begin
            s1_prod_reg <= prod_next;
            s1_a_reg    <= a;
            s1_ctl_reg  <= ctl;
            s1_tag_reg  <= up_tag;
        end
        if (s2_ready && s1_valid_reg)
        begin
            s2_res_reg <= res_next;
            s2_tag_reg <= s1_tag_reg;
        end
    end

    assign dn_valid = s2_valid_reg;
    assign res      = s2_res_reg;
    assign dn_tag   = s2_tag_reg;

endmodule

`default_nettype wire

FILE: sv/quaternion_multiply_rotate.sv
// The unit takes one word per cycle unless the output stalls.
// The four stages are two Hamilton product pipes
// (16 registered 32x32 multipliers and one sum stage each) in series.
// A stalled output holds only the stages behind it; empty stages keep filling.
// Reset (rst_n, asynchronous) empties all stages; the data registers are not reset.
// Depends on qmr_pkg and qmr_ham_pipe.
`default_nettype none

module quaternion_multiply_rotate
    import qmr_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_ready,
    input  wire logic  cmd,
    input  wire word_t first_w,
    input  wire word_t first_x,
    input  wire word_t first_y,
    input  wire word_t first_z,
    input  wire word_t second_w,
    input  wire word_t second_x,
    input  wire word_t second_y,
    input  wire word_t second_z,
    output logic       out_valid,
    input  wire logic  out_ready,
    output word_t      out_w,
    output word_t      out_x,
    output word_t      out_y,
    output word_t      out_z
);

    quat_t    qa;
    quat_t    qb;
    ham_ctl_t ctl1;
    tag_t     tag1;
    logic     mid_valid;
    logic     mid_ready;
    quat_t    mid_res;
    tag_t     mid_tag;
    quat_t    qc;
    ham_ctl_t ctl2;
    quat_t    fin_res;
    tag_t     fin_tag;

    always_comb
    begin
        qa.w = first_w;
        qa.x = first_x;
        qa.y = first_y;
        qa.z = first_z;
        // rotation treats the vector as a pure quaternion
        qb.w = (cmd == CMD_ROTATE) ? '0 : second_w;
        qb.x = second_x;
        qb.y = second_y;
        qb.z = second_z;
        ctl1.pass   = 1'b0;
        ctl1.zero_w = 1'b0;
        tag1.cmd    = cmd;
        tag1.conj.w = first_w;
        tag1.conj.x = '0 - first_x;
        tag1.conj.y = '0 - first_y;
        tag1.conj.z = '0 - first_z;
    end

    qmr_ham_pipe u_first
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (in_valid),
        .up_ready (in_ready),
        .a        (qa),
        .b        (qb),
        .ctl      (ctl1),
        .up_tag   (tag1),
        .dn_valid (mid_valid),
        .dn_ready (mid_ready),
        .res      (mid_res),
        .dn_tag   (mid_tag)
    );

    // multiply words skip the second product; rotation multiplies by conj(q)
    always_comb
    begin
        qc          = mid_tag.conj;
        ctl2.pass   = (mid_tag.cmd == CMD_MULTIPLY);
        ctl2.zero_w = (mid_tag.cmd == CMD_ROTATE);
    end

    qmr_ham_pipe u_second
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (mid_valid),
        .up_ready (mid_ready),
        .a        (mid_res),
        .b        (qc),
        .ctl      (ctl2),
        .up_tag   (mid_tag),
        .dn_valid (out_valid),
        .dn_ready (out_ready),
        .res      (fin_res),
        .dn_tag   (fin_tag)
    );

    assign out_w = fin_res.w;
    assign out_x = fin_res.x;
    assign out_y = fin_res.y;
    assign out_z = fin_res.z;

`ifndef SYNTHESIS
    a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("input not ready while output drains");

    a_rotate_w_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && fin_tag.cmd == CMD_ROTATE) |-> out_w == '0)
        else $error("rotation result has nonzero scalar part");

    a_mid_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (mid_valid && !mid_ready) |-> out_valid)
        else $error("second pipe stalls with an empty output stage");

    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_ready) |-> mid_valid)
        else $error("first pipe stalls with an empty output stage");
`endif

endmodule

`default_nettype wire

FILE: test/quaternion_multiply_rotate_tb.sv
// Testbench for quaternion_multiply_rotate: a table of directed words, then random words.
// Each result is checked against its table entry or the fixed-point predictor in this file.
// Depends on qmr_pkg and the RTL of the unit.

module quaternion_multiply_rotate_tb
    import qmr_pkg::*;
();

    localparam int DIRECTED_ROWS = 18;
    localparam int RANDOM_WORDS  = 1332;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int DRAIN_CYCLES  = 8;

    localparam word_t ZERO    = 32'sh0000_0000;
    localparam word_t ONE     = 32'sh0001_0000;
    localparam word_t NEG_ONE = 32'shFFFF_0000;
    localparam word_t LSB     = 32'sh0000_0001;
    localparam word_t NEG_LSB = 32'shFFFF_FFFF;
    localparam word_t MAX_W   = 32'sh7FFF_FFFF;
    localparam word_t MIN_W   = 32'sh8000_0000;
    localparam word_t HALF_RT = 32'sh0000_B505;  // about 0.7071

    typedef struct {
        logic  op;
        quat_t first;
        quat_t second;
        bit    typed;
        quat_t want;
    } stim_row_t;

    logic  clk = 1'b0;
    logic  rst_n;
    logic  in_valid;
    logic  in_ready;
    logic  cmd;
    word_t first_w, first_x, first_y, first_z;
    word_t second_w, second_x, second_y, second_z;
    logic  out_valid;
    logic  out_ready;
    word_t out_w, out_x, out_y, out_z;

    quat_t     pending_products[$];
    stim_row_t directed_rows[DIRECTED_ROWS];
    int        mismatch_count = 0;
    int        cycle_count    = 0;
    bit        sender_calm    = 1'b0;
    bit        receiver_calm  = 1'b0;

    quaternion_multiply_rotate DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .first_w  (first_w),
        .first_x  (first_x),
        .first_y  (first_y),
        .first_z  (first_z),
        .second_w (second_w),
        .second_x (second_x),
        .second_y (second_y),
        .second_z (second_z),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_w    (out_w),
        .out_x    (out_x),
        .out_y    (out_y),
        .out_z    (out_z)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Q16.16 product: full 64-bit signed product, floor shift, low 32 bits
    function automatic word_t q16_mul(input word_t a, input word_t b);
        longint signed prod;
        prod = longint'(a) * longint'(b);
        return word_t'(prod >>> FRAC_BITS);
    endfunction

    function automatic quat_t hamilton_product(input quat_t a, input quat_t b);
        quat_t r;
        r.w = q16_mul(a.w, b.w) - q16_mul(a.x, b.x) - q16_mul(a.y, b.y) - q16_mul(a.z, b.z);
        r.x = q16_mul(a.w, b.x) + q16_mul(a.x, b.w) + q16_mul(a.y, b.z) - q16_mul(a.z, b.y);
        r.y = q16_mul(a.w, b.y) + q16_mul(a.y, b.w) + q16_mul(a.z, b.x) - q16_mul(a.x, b.z);
        r.z = q16_mul(a.w, b.z) + q16_mul(a.z, b.w) + q16_mul(a.x, b.y) - q16_mul(a.y, b.x);
        return r;
    endfunction

    function automatic quat_t predict_result(input logic op, input quat_t a, input quat_t b);
        quat_t conj_a;
        quat_t r;
        if (op == CMD_MULTIPLY)
        begin
            return hamilton_product(a, b);
        end
        // negation wraps, so the most negative value is its own conjugate
        conj_a = '{a.w, -a.x, -a.y, -a.z};
        b.w = ZERO;
        r = hamilton_product(hamilton_product(a, b), conj_a);
        r.w = ZERO;
        return r;
    endfunction

    function automatic quat_t quat(input word_t w, input word_t x, input word_t y,
                                   input word_t z);
        return '{w, x, y, z};
    endfunction

    function automatic stim_row_t row(input logic op, input quat_t a, input quat_t b,
                                      input bit typed, input quat_t want);
        stim_row_t r;
        r.op     = op;
        r.first  = a;
        r.second = b;
        r.typed  = typed;
        r.want   = want;
        return r;
    endfunction

    function automatic word_t random_word();
        case ($urandom_range(0, 5))
            0, 1: return word_t'($urandom);
            2: return word_t'($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
            3: return word_t'($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
            4:
            begin
                case ($urandom_range(0, 5))
                    0: return MIN_W;
                    1: return MAX_W;
                    2: return ZERO;
                    3: return NEG_LSB;
                    4: return ONE;
                    default: return NEG_ONE;
                endcase
            end
            default: return word_t'($urandom_range(0, 32'h0002_0000)) - 32'sh0001_0000;
        endcase
    endfunction

    function automatic quat_t random_quat();
        return quat(random_word(), random_word(), random_word(), random_word());
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t ERROR: %s", $realtime, what);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input word_t got, input word_t want);
        if (got !== want)
        begin
            report_mismatch($sformatf("%s got %h expected %h", name, got, want));
        end
    endtask

    // Present one word from a falling edge and hold it until it is taken.
    task automatic send_word(input logic op, input quat_t a, input quat_t b, input bit typed,
                             input quat_t want);
        int gap;
        if ($urandom_range(0, 39) == 0)
        begin
            sender_calm = !sender_calm;
        end
        gap = sender_calm ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd      <= op;
        first_w  <= a.w;
        first_x  <= a.x;
        first_y  <= a.y;
        first_z  <= a.z;
        second_w <= b.w;
        second_x <= b.x;
        second_y <= b.y;
        second_z <= b.z;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        pending_products.push_back(typed ? want : predict_result(op, a, b));
        @(negedge clk);
    endtask

    task automatic wait_drained();
        while (pending_products.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    always @(posedge clk)
    begin : result_check
        quat_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_products.size() == 0)
            begin
                report_mismatch($sformatf("result word %h %h %h %h with nothing expected",
                                          out_w, out_x, out_y, out_z));
            end
            else
            begin
                want = pending_products.pop_front();
                check_field("out_w", out_w, want.w);
                check_field("out_x", out_x, want.x);
                check_field("out_y", out_y, want.y);
                check_field("out_z", out_z, want.z);
            end
        end
    end

    // Output side: stall a random number of cycles before each word, with calm stretches.
    initial
    begin : result_sink
        int stall;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 39) == 0)
            begin
                receiver_calm = !receiver_calm;
            end
            stall = receiver_calm ? 0 : $urandom_range(0, 9);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
            begin
                @(posedge clk);
            end
            @(negedge clk);
        end
    end

    initial
    begin : stimulus
        logic  op;
        quat_t none;
        none     = quat(ZERO, ZERO, ZERO, ZERO);
        rst_n    = 1'b0;
        in_valid = 1'b0;
        cmd      = CMD_MULTIPLY;
        first_w  = ZERO;
        first_x  = ZERO;
        first_y  = ZERO;
        first_z  = ZERO;
        second_w = ZERO;
        second_x = ZERO;
        second_y = ZERO;
        second_z = ZERO;

        directed_rows[0]  = row(CMD_MULTIPLY, none, none, 1'b1, none);
        directed_rows[1]  = row(CMD_MULTIPLY, quat(ONE, ZERO, ZERO, ZERO),
                                quat(MAX_W, MIN_W, 32'sh0001_E240, -32'sd7), 1'b1,
                                quat(MAX_W, MIN_W, 32'sh0001_E240, -32'sd7));
        directed_rows[2]  = row(CMD_MULTIPLY, quat(ZERO, ONE, ZERO, ZERO),
                                quat(ZERO, ONE, ZERO, ZERO), 1'b1,
                                quat(NEG_ONE, ZERO, ZERO, ZERO));
        directed_rows[3]  = row(CMD_MULTIPLY, quat(ZERO, ONE, ZERO, ZERO),
                                quat(ZERO, ZERO, ONE, ZERO), 1'b1,
                                quat(ZERO, ZERO, ZERO, ONE));
        // product of -1 and +1 lsb floors to -1 lsb
        directed_rows[4]  = row(CMD_MULTIPLY, quat(NEG_LSB, ZERO, ZERO, ZERO),
                                quat(LSB, ZERO, ZERO, ZERO), 1'b1,
                                quat(NEG_LSB, ZERO, ZERO, ZERO));
        // identity rotation: scalar input ignored, scalar output forced to zero
        directed_rows[5]  = row(CMD_ROTATE, quat(ONE, ZERO, ZERO, ZERO),
                                quat(MAX_W, ONE, MIN_W, MAX_W), 1'b1,
                                quat(ZERO, ONE, MIN_W, MAX_W));
        directed_rows[6]  = row(CMD_ROTATE, none, quat(MIN_W, MAX_W, ONE, NEG_ONE), 1'b1,
                                none);
        // non-unit quaternion of 2.0 scales the vector by four
        directed_rows[7]  = row(CMD_ROTATE, quat(2 * ONE, ZERO, ZERO, ZERO),
                                quat(ZERO, ONE, 2 * ONE, 3 * ONE), 1'b1,
                                quat(ZERO, 4 * ONE, 8 * ONE, 12 * ONE));
        directed_rows[8]  = row(CMD_MULTIPLY, quat(MAX_W, MAX_W, MAX_W, MAX_W),
                                quat(MAX_W, MAX_W, MAX_W, MAX_W), 1'b0, none);
        directed_rows[9]  = row(CMD_MULTIPLY, quat(MIN_W, MIN_W, MIN_W, MIN_W),
                                quat(MIN_W, MIN_W, MIN_W, MIN_W), 1'b0, none);
        directed_rows[10] = row(CMD_MULTIPLY, quat(MIN_W, MAX_W, MIN_W, MAX_W),
                                quat(MAX_W, MIN_W, MAX_W, MIN_W), 1'b0, none);
        directed_rows[11] = row(CMD_ROTATE, quat(ZERO, MIN_W, ZERO, ZERO),
                                quat(ZERO, ONE, ONE, ONE), 1'b0, none);
        directed_rows[12] = row(CMD_ROTATE, quat(MIN_W, MIN_W, MIN_W, MIN_W),
                                quat(ZERO, MAX_W, MAX_W, MAX_W), 1'b0, none);
        directed_rows[13] = row(CMD_ROTATE, quat(MAX_W, MAX_W, MAX_W, MAX_W),
                                quat(MIN_W, MIN_W, MIN_W, MIN_W), 1'b0, none);
        directed_rows[14] = row(CMD_ROTATE, quat(HALF_RT, ZERO, ZERO, HALF_RT),
                                quat(ZERO, ONE, ZERO, ZERO), 1'b0, none);
        directed_rows[15] = row(CMD_MULTIPLY, quat(NEG_LSB, NEG_LSB, NEG_LSB, NEG_LSB),
                                quat(NEG_LSB, NEG_LSB, NEG_LSB, NEG_LSB), 1'b0, none);
        directed_rows[16] = row(CMD_MULTIPLY,
                                quat(32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555,
                                     32'shAAAA_AAAA),
                                quat(32'shAAAA_AAAA, 32'sh5555_5555, 32'shAAAA_AAAA,
                                     32'sh5555_5555), 1'b0, none);
        directed_rows[17] = row(CMD_ROTATE,
                                quat(32'sh1234_5678, 32'shEDCB_A987, 32'sh0F0F_0F0F,
                                     32'shF0F0_F0F0),
                                quat(32'sh7654_3210, 32'sh89AB_CDEF, 32'sh3C3C_3C3C,
                                     32'shC3C3_C3C3), 1'b0, none);

        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            send_word(directed_rows[i].op, directed_rows[i].first, directed_rows[i].second,
                      directed_rows[i].typed, directed_rows[i].want);
        end

        // hold the input until the pipe has emptied
        in_valid <= 1'b0;
        wait_drained();

        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            if (i == RANDOM_WORDS / 2)
            begin
                in_valid <= 1'b0;
                wait_drained();
            end
            op = ($urandom_range(0, 1) == 1) ? CMD_ROTATE : CMD_MULTIPLY;
            send_word(op, random_quat(), random_quat(), 1'b0, none);
        end

        in_valid <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (mismatch_count == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

FILE: filelist.f
sv/qmr_pkg.sv
sv/qmr_ham_pipe.sv
sv/quaternion_multiply_rotate.sv
test/quaternion_multiply_rotate_tb.sv
